// ===== hdl/epc_pkg.sv =====
// Shared constants and codes for the exact point counter.
// No dependencies; imported by the top module, epc_hash and the testbench.
`default_nettype none
package epc_pkg;

    localparam logic [63:0] GOLDEN   = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] GOLDEN2  = 64'h3c6ef372fe94f82a;
    localparam logic [63:0] MIX_K1   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_K2   = 64'h94d049bb133111eb;
    localparam logic [63:0] MAG_MASK = 64'h7fffffffffffffff;
    localparam logic [63:0] EXP_MASK = 64'h7ff0000000000000;

    localparam int COORD_W   = 64;
    localparam int SLOT_IN_W = 10;
    localparam int ENTRIES_W = 11;
    localparam int OUTCNT_W  = 32;

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // Channel offset ch * GOLDEN, modulo 2^64, for ch 0 to 2
    function automatic logic [63:0] chan_offset(input logic [1:0] ch);
        logic [63:0] r;
        begin
            case (ch)
                2'd0:    r = 64'd0;
                2'd1:    r = GOLDEN;
                default: r = GOLDEN2;
            endcase
            return r;
        end
    endfunction

    // Replace a zero of either sign by +0
    function automatic logic [63:0] norm_zero(input logic [63:0] b);
        begin
            return ((b & MAG_MASK) == 64'd0) ? 64'd0 : b;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hdl/exact_point_count_hash_table.sv =====
// Channel  | signals                                    | payload
// s_axis   | tvalid tready tdata[207:0] tuser[1:0]      | request: func, coordinates, slot
// m_axis   | tvalid tready tdata[239:0] tuser[1:0]      | result: status, slot fields, occupancy
//
// Add: the request is taken, hashed on one shared 32x32 multiplier, the hash is taken, each
// probed slot is read and compared on the single table RAM port, and the result is loaded.
// Read: the slot is read, then the result is loaded. Clear: the table is swept, then the result is loaded.
// After reset the table RAM is swept once before the first request.
// One request at a time; a finished result waits in the output register while the next
// request is accepted, and the block holds in its final state while the result is stalled.
// Depends on epc_pkg, epc_hash, epc_ram.
`default_nettype none
module exact_point_count_hash_table #(
    parameter int TABLE_SLOTS = 1024,
    parameter int COUNT_BITS  = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // coord_x[63:0], coord_y[127:64], coord_z[191:128], slot_index[201:192], zero fill
    input  wire logic [207:0] s_axis_tdata,
    // func[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // slot_used[0], out_x[64:1], out_y[128:65], out_z[192:129],
    // seen_count[224:193], entries_used[235:225], zero fill
    output logic      [239:0] m_axis_tdata,
    // status[1:0]
    output logic      [1:0]   m_axis_tuser
);
    import epc_pkg::*;

    localparam int IW    = $clog2(TABLE_SLOTS);
    localparam int TW    = $clog2(TABLE_SLOTS + 1);
    localparam int RW    = 1 + COUNT_BITS + 3 * COORD_W;
    localparam int LIMIT = (TABLE_SLOTS * 7) / 10;
    localparam logic [IW-1:0]         LAST_SLOT = IW'(TABLE_SLOTS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_HASH, S_PRB_RD, S_PRB_CMP, S_RD_RD, S_RD_WT, S_DONE
    } state_t;

    state_t              state_reg;
    logic                clr_report_reg;
    logic [IW-1:0]       clr_idx_reg, slot_reg, n_reg;
    logic [TW-1:0]       total_reg;
    logic [63:0]         cx_reg, cy_reg, cz_reg;
    logic [1:0]          res_status_reg;
    logic                res_used_reg;
    logic [63:0]         res_x_reg, res_y_reg, res_z_reg;
    logic [COUNT_BITS-1:0] res_cnt_reg;
    logic                m_valid_reg;
    logic [239:0]        m_data_reg;
    logic [1:0]          m_user_reg;

    logic [63:0]         in_x, in_y, in_z;
    logic [SLOT_IN_W-1:0] in_slot;
    logic                in_bad, accept, hash_start, hash_done;
    logic [63:0]         hash;
    logic                ram_we;
    logic [IW-1:0]       ram_addr;
    logic [RW-1:0]       ram_wdata, ram_rdata;
    logic                r_occ, r_match, insert_ok, out_free;
    logic [COUNT_BITS-1:0] r_cnt, cnt_inc;
    logic [63:0]         r_x, r_y, r_z;

    // Unpack and normalize the request
    assign in_x    = norm_zero(s_axis_tdata[63:0]);
    assign in_y    = norm_zero(s_axis_tdata[127:64]);
    assign in_z    = norm_zero(s_axis_tdata[191:128]);
    assign in_slot = s_axis_tdata[201:192];
    assign in_bad  = ((in_x & EXP_MASK) == EXP_MASK) || ((in_y & EXP_MASK) == EXP_MASK)
                  || ((in_z & EXP_MASK) == EXP_MASK);
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign hash_start    = accept && s_axis_tuser == FUNC_ADD && !in_bad;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // Decode the slot word read back
    assign r_x     = ram_rdata[63:0];
    assign r_y     = ram_rdata[127:64];
    assign r_z     = ram_rdata[191:128];
    assign r_cnt   = ram_rdata[RW-2:192];
    assign r_occ   = ram_rdata[RW-1];
    assign r_match = r_occ && r_x == cx_reg && r_y == cy_reg && r_z == cz_reg;
    assign cnt_inc = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + COUNT_BITS'(1);
    assign insert_ok = (32'(total_reg) + 32'd1) <= 32'(LIMIT);

    // Drive the table port
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = slot_reg;
        ram_wdata = {1'b1, cnt_inc, r_z, r_y, r_x};
        case (state_reg)
            S_CLR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_idx_reg;
                ram_wdata = '0;
            end
            S_PRB_CMP:
            begin
                if (r_match)
                begin
                    ram_we = 1'b1;
                end
                else if (!r_occ)
                begin
                    ram_we    = insert_ok;
                    ram_wdata = {1'b1, COUNT_BITS'(1), cz_reg, cy_reg, cx_reg};
                end
            end
            default: ram_addr = slot_reg;
        endcase
    end

    epc_hash u_hash (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (hash_start),
        .coord_x (cx_reg),
        .coord_y (cy_reg),
        .coord_z (cz_reg),
        .done    (hash_done),
        .hash    (hash)
    );

    epc_ram #(.WIDTH(RW), .DEPTH(TABLE_SLOTS)) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Sequence requests, probes, sweeps and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            clr_report_reg <= 1'b0;
            clr_idx_reg    <= '0;
            total_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (m_valid_reg && m_axis_tready && state_reg != S_DONE)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLR:
                begin
                    clr_idx_reg <= clr_idx_reg + IW'(1);
                    if (clr_idx_reg == LAST_SLOT)
                    begin
                        clr_idx_reg <= '0;
                        total_reg   <= '0;
                        state_reg   <= clr_report_reg ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cx_reg         <= in_x;
                        cy_reg         <= in_y;
                        cz_reg         <= in_z;
                        res_status_reg <= ST_OK;
                        res_used_reg   <= 1'b0;
                        res_x_reg      <= '0;
                        res_y_reg      <= '0;
                        res_z_reg      <= '0;
                        res_cnt_reg    <= '0;
                        slot_reg       <= IW'(in_slot);
                        case (s_axis_tuser)
                            FUNC_ADD:
                            begin
                                if (in_bad)
                                begin
                                    res_status_reg <= ST_INVALID;
                                    state_reg      <= S_DONE;
                                end
                                else
                                begin
                                    state_reg <= S_HASH;
                                end
                            end
                            FUNC_READ:
                            begin
                                if (32'(in_slot) < 32'(TABLE_SLOTS))
                                begin
                                    state_reg <= S_RD_RD;
                                end
                                else
                                begin
                                    state_reg <= S_DONE;
                                end
                            end
                            FUNC_CLEAR:
                            begin
                                clr_report_reg <= 1'b1;
                                state_reg      <= S_CLR;
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_HASH:
                begin
                    if (hash_done)
                    begin
                        slot_reg  <= hash[IW-1:0];
                        n_reg     <= '0;
                        state_reg <= S_PRB_RD;
                    end
                end
                S_PRB_RD: state_reg <= S_PRB_CMP;
                S_PRB_CMP:
                begin
                    if (r_match)
                    begin
                        res_used_reg <= 1'b1;
                        res_x_reg    <= r_x;
                        res_y_reg    <= r_y;
                        res_z_reg    <= r_z;
                        res_cnt_reg  <= cnt_inc;
                        state_reg    <= S_DONE;
                    end
                    else if (!r_occ)
                    begin
                        if (insert_ok)
                        begin
                            res_used_reg <= 1'b1;
                            res_x_reg    <= cx_reg;
                            res_y_reg    <= cy_reg;
                            res_z_reg    <= cz_reg;
                            res_cnt_reg  <= COUNT_BITS'(1);
                            total_reg    <= total_reg + TW'(1);
                        end
                        else
                        begin
                            res_status_reg <= ST_FULL;
                        end
                        state_reg <= S_DONE;
                    end
                    else if (n_reg == LAST_SLOT)
                    begin
                        res_status_reg <= ST_FULL;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        n_reg     <= n_reg + IW'(1);
                        slot_reg  <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + IW'(1);
                        state_reg <= S_PRB_RD;
                    end
                end
                S_RD_RD: state_reg <= S_RD_WT;
                S_RD_WT:
                begin
                    if (r_occ)
                    begin
                        res_used_reg <= 1'b1;
                        res_x_reg    <= r_x;
                        res_y_reg    <= r_y;
                        res_z_reg    <= r_z;
                        res_cnt_reg  <= r_cnt;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        m_valid_reg    <= 1'b1;
                        m_user_reg     <= res_status_reg;
                        m_data_reg     <= {4'd0, ENTRIES_W'(total_reg),
                                           OUTCNT_W'(res_cnt_reg), res_z_reg, res_y_reg,
                                           res_x_reg, res_used_reg};
                        clr_report_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

`ifndef ASSERT_OFF
    a_total_limit: assert property (@(posedge clk) disable iff (!rst_n)
        32'(total_reg) <= 32'(LIMIT))
        else $error("occupancy above load limit");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_axis_tready)
        else $error("ready right after a request");
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLR || state_reg == S_PRB_CMP))
        else $error("table write outside sweep or probe");
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_axis_tready) |=> $stable(m_data_reg))
        else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

// ===== hdl/epc_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module epc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read one address a cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

// ===== hdl/epc_hash.sv =====
// Point hash: six splitmix64 finalizers on one shared 32x32 multiplier.
// Depends on epc_pkg.
`default_nettype none
module epc_hash (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] coord_x,
    input  wire logic [63:0] coord_y,
    input  wire logic [63:0] coord_z,
    output logic             done,
    output logic      [63:0] hash
);
    import epc_pkg::*;

    typedef enum logic [1:0] {H_IDLE, H_LOAD, H_MIX, H_FOLD} hstate_t;

    hstate_t     state_reg;
    logic [63:0] v_reg, h_reg, acc_reg, p_reg;
    logic [3:0]  ph_reg;
    logic [1:0]  ch_reg;
    logic        second_reg, done_reg;

    logic [63:0] k_sel, coord_sel, prod, v_xs;
    logic [31:0] mul_a, mul_b;

    // Pick the constant, the operand halves and the shift for this phase
    always_comb
    begin
        k_sel = (ph_reg < 4'd5) ? MIX_K1 : MIX_K2;
        mul_a = (ph_reg == 4'd3 || ph_reg == 4'd8) ? v_reg[63:32] : v_reg[31:0];
        mul_b = (ph_reg == 4'd2 || ph_reg == 4'd7) ? k_sel[63:32] : k_sel[31:0];
        prod  = 64'(mul_a) * 64'(mul_b);
        case (ph_reg)
            4'd0:    v_xs = v_reg ^ (v_reg >> 30);
            4'd5:    v_xs = v_reg ^ (v_reg >> 27);
            default: v_xs = v_reg ^ (v_reg >> 31);
        endcase
        case (ch_reg)
            2'd0:    coord_sel = coord_x;
            2'd1:    coord_sel = coord_y;
            default: coord_sel = coord_z;
        endcase
    end

    // Sequence loads, mix phases and folds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= H_IDLE;
            ph_reg     <= 4'd0;
            ch_reg     <= 2'd0;
            second_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                H_IDLE:
                begin
                    if (start)
                    begin
                        h_reg     <= GOLDEN;
                        ch_reg    <= 2'd0;
                        state_reg <= H_LOAD;
                    end
                end
                H_LOAD:
                begin
                    v_reg      <= coord_sel + chan_offset(ch_reg);
                    second_reg <= 1'b0;
                    ph_reg     <= 4'd0;
                    state_reg  <= H_MIX;
                end
                H_FOLD:
                begin
                    v_reg      <= h_reg ^ v_reg;
                    second_reg <= 1'b1;
                    ph_reg     <= 4'd0;
                    state_reg  <= H_MIX;
                end
                H_MIX:
                begin
                    ph_reg <= ph_reg + 4'd1;
                    case (ph_reg)
                        4'd0, 4'd5: v_reg <= v_xs;
                        4'd1, 4'd6: p_reg <= prod;
                        4'd2, 4'd7:
                        begin
                            acc_reg <= p_reg;
                            p_reg   <= prod;
                        end
                        4'd3, 4'd8:
                        begin
                            acc_reg <= acc_reg + {p_reg[31:0], 32'd0};
                            p_reg   <= prod;
                        end
                        4'd4, 4'd9: v_reg <= acc_reg + {p_reg[31:0], 32'd0};
                        default:
                        begin
                            v_reg <= v_xs;
                            if (!second_reg)
                            begin
                                state_reg <= H_FOLD;
                            end
                            else
                            begin
                                h_reg <= v_xs;
                                if (ch_reg == 2'd2)
                                begin
                                    done_reg  <= 1'b1;
                                    state_reg <= H_IDLE;
                                end
                                else
                                begin
                                    ch_reg    <= ch_reg + 2'd1;
                                    state_reg <= H_LOAD;
                                end
                            end
                        end
                    endcase
                end
                default: state_reg <= H_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign hash = h_reg;

`ifndef ASSERT_OFF
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && state_reg == H_IDLE) |=> !done)
        else $error("hash done right after start");
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == H_MIX |-> ph_reg <= 4'd10)
        else $error("mix phase out of range");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == H_IDLE && ch_reg == 2'd2)
        else $error("done without finishing all channels");
`endif

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for exact_point_count_hash_table: drives add, read, clear and
// unused requests and checks every result against a built-in hash table predictor.
// Depends on epc_pkg and the RTL of the block.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import epc_pkg::*;

    localparam int SLOTS      = 1024;
    localparam int LONG_HOLD  = 400;
    localparam int WATCH_MAX  = 30000;
    localparam int DRAIN_WAIT = 300;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    typedef struct {
        logic [1:0]  status;
        logic        used;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] z;
        logic [31:0] cnt;
        logic [10:0] entries;
    } result_t;

    // Hash table predictor and store of expected results
    class count_scoreboard;
        bit          occupied[SLOTS];
        bit [63:0]   tab_x[SLOTS];
        bit [63:0]   tab_y[SLOTS];
        bit [63:0]   tab_z[SLOTS];
        bit [63:0]   tab_h[SLOTS];
        bit [31:0]   tab_cnt[SLOTS];
        int unsigned total;
        result_t     expected_results[$];
        int unsigned failures;
        int unsigned checked;
        int unsigned n_full;
        int unsigned n_invalid;
        int unsigned n_hit;

        function bit [63:0] splitmix(bit [63:0] v);
            v = v ^ (v >> 30);
            v = v * MIX_K1;
            v = v ^ (v >> 27);
            v = v * MIX_K2;
            v = v ^ (v >> 31);
            return v;
        endfunction

        function bit [63:0] fold_zero(bit [63:0] b);
            return ((b & MAG_MASK) == 64'd0) ? 64'd0 : b;
        endfunction

        function bit [63:0] point_key(bit [63:0] x, bit [63:0] y, bit [63:0] z);
            bit [63:0] h;
            h = GOLDEN;
            h = splitmix(h ^ splitmix(fold_zero(x)));
            h = splitmix(h ^ splitmix(fold_zero(y) + GOLDEN));
            h = splitmix(h ^ splitmix(fold_zero(z) + GOLDEN * 64'd2));
            return h;
        endfunction

        // Work out the result of one accepted request and update the table
        function void note_request(logic [1:0] func, bit [63:0] x, bit [63:0] y,
                                   bit [63:0] z, bit [9:0] idx);
            result_t r;
            bit [63:0] cx, cy, cz, h;
            int slot;
            bit hit, empty;
            r = '{status: ST_OK, used: 1'b0, x: 64'd0, y: 64'd0, z: 64'd0,
                  cnt: 32'd0, entries: 11'd0};
            if (func == FUNC_ADD) begin
                cx = fold_zero(x);
                cy = fold_zero(y);
                cz = fold_zero(z);
                if ((cx & EXP_MASK) == EXP_MASK || (cy & EXP_MASK) == EXP_MASK ||
                    (cz & EXP_MASK) == EXP_MASK) begin
                    r.status = ST_INVALID;
                    n_invalid++;
                end else begin
                    h = point_key(cx, cy, cz);
                    slot = int'(h[9:0]);
                    hit = 0;
                    empty = 0;
                    // linear probe, at most one lap
                    for (int n = 0; n < SLOTS; n++) begin
                        if (!occupied[slot]) begin
                            empty = 1;
                            break;
                        end
                        if (tab_h[slot] == h && tab_x[slot] == cx && tab_y[slot] == cy &&
                            tab_z[slot] == cz) begin
                            hit = 1;
                            break;
                        end
                        slot = (slot + 1) % SLOTS;
                    end
                    if (hit) begin
                        n_hit++;
                        if (tab_cnt[slot] != 32'hffffffff)
                            tab_cnt[slot]++;
                    end else if (!empty || (total + 1) * 10 > SLOTS * 7) begin
                        r.status = ST_FULL;
                        n_full++;
                    end else begin
                        occupied[slot] = 1;
                        tab_h[slot] = h;
                        tab_x[slot] = cx;
                        tab_y[slot] = cy;
                        tab_z[slot] = cz;
                        tab_cnt[slot] = 32'd1;
                        total++;
                    end
                    if (r.status == ST_OK) begin
                        r.used = 1'b1;
                        r.x = tab_x[slot];
                        r.y = tab_y[slot];
                        r.z = tab_z[slot];
                        r.cnt = tab_cnt[slot];
                    end
                end
            end else if (func == FUNC_READ) begin
                if (occupied[idx]) begin
                    r.used = 1'b1;
                    r.x = tab_x[idx];
                    r.y = tab_y[idx];
                    r.z = tab_z[idx];
                    r.cnt = tab_cnt[idx];
                end
            end else if (func == FUNC_CLEAR) begin
                foreach (occupied[i])
                    occupied[i] = 0;
                total = 0;
            end
            r.entries = total[10:0];
            expected_results.push_back(r);
        endfunction

        function void compare(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
                failures++;
            end
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(result_t act);
            result_t e;
            if (expected_results.size() == 0) begin
                $error("result arrived with nothing expected");
                failures++;
                return;
            end
            e = expected_results.pop_front();
            checked++;
            compare("status", 64'(e.status), 64'(act.status));
            compare("slot_used", 64'(e.used), 64'(act.used));
            compare("out_x", e.x, act.x);
            compare("out_y", e.y, act.y);
            compare("out_z", e.z, act.z);
            compare("seen_count", 64'(e.cnt), 64'(act.cnt));
            compare("entries_used", 64'(e.entries), 64'(act.entries));
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [207:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [239:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    count_scoreboard sb = new();
    bit          calm = 0;
    bit          long_hold_req = 0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned n_sent = 0;
    logic [63:0] pool_x[$], pool_y[$], pool_z[$];

    exact_point_count_hash_table u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Note accepted requests and check accepted results
    always @(posedge clk)
    begin
        result_t act;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_request(s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[127:64],
                            s_axis_tdata[191:128], s_axis_tdata[201:192]);
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            act.status  = m_axis_tuser;
            act.used    = m_axis_tdata[0];
            act.x       = m_axis_tdata[64:1];
            act.y       = m_axis_tdata[128:65];
            act.z       = m_axis_tdata[192:129];
            act.cnt     = m_axis_tdata[224:193];
            act.entries = m_axis_tdata[235:225];
            sb.check_result(act);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: random stall bursts, one long hold-off on request
    always @(negedge clk)
    begin
        if (long_hold_req && hold_left == 0) begin
            long_hold_req = 0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            m_axis_tready = 1'b0;
            hold_left--;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            m_axis_tready = 1'b0;
            hold_left = $urandom_range(0, 8);
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    // Offer one request and hold it until accepted
    task automatic send_request(logic [1:0] func, logic [63:0] x, logic [63:0] y,
                                logic [63:0] z, logic [9:0] idx);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = func;
        s_axis_tdata  = {6'd0, idx, z, y, x};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        n_sent++;
    endtask

    // Lower valid and wait until every expected result has come
    task automatic wait_results_done();
        s_axis_tvalid = 1'b0;
        while (sb.expected_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random finite coordinate, sometimes a signed zero
    function automatic logic [63:0] finite64();
        logic [63:0] v;
        v = rand64();
        if ($urandom_range(0, 15) == 0)
            v = {v[63], 63'd0};
        if ((v & EXP_MASK) == EXP_MASK)
            v[62] = 1'b0;
        return v;
    endfunction

    task automatic add_pool_point();
        int k;
        logic [63:0] px, py, pz;
        k = $urandom_range(0, pool_x.size() - 1);
        px = pool_x[k];
        py = pool_y[k];
        pz = pool_z[k];
        // flip the sign of a zero coordinate: still the same point
        if (px[62:0] == 63'd0 && $urandom_range(0, 1)) px[63] = ~px[63];
        if (pz[62:0] == 63'd0 && $urandom_range(0, 1)) pz[63] = ~pz[63];
        send_request(FUNC_ADD, px, py, pz, 10'($urandom()));
    endtask

    task automatic add_fresh_point();
        logic [63:0] px, py, pz;
        px = finite64();
        py = finite64();
        pz = finite64();
        if (pool_x.size() < 64) begin
            pool_x.push_back(px);
            pool_y.push_back(py);
            pool_z.push_back(pz);
        end
        send_request(FUNC_ADD, px, py, pz, 10'($urandom()));
    endtask

    task automatic add_bad_point();
        logic [63:0] v[3];
        int k;
        v[0] = finite64();
        v[1] = finite64();
        v[2] = finite64();
        k = $urandom_range(0, 2);
        v[k] = v[k] | EXP_MASK;
        send_request(FUNC_ADD, v[0], v[1], v[2], 10'($urandom()));
    endtask

    task automatic mixed_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45 && pool_x.size() > 0)
            add_pool_point();
        else if (pick < 60)
            add_fresh_point();
        else if (pick < 66)
            add_bad_point();
        else if (pick < 94)
            send_request(FUNC_READ, rand64(), rand64(), rand64(), 10'($urandom()));
        else if (pick < 97)
            send_request(FUNC_NONE, rand64(), rand64(), rand64(), 10'($urandom()));
        else
            send_request(FUNC_CLEAR, rand64(), rand64(), rand64(), 10'($urandom()));
    endtask

    initial
    begin
        logic [63:0] h;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed: signed zeros, extremes, invalid inputs, reads, unused code, clear
        send_request(FUNC_ADD, 64'd0, 64'd0, 64'd0, 10'd0);
        send_request(FUNC_ADD, 64'h8000000000000000, 64'h8000000000000000,
                     64'h8000000000000000, 10'h3ff);
        send_request(FUNC_ADD, 64'h7fefffffffffffff, 64'hffefffffffffffff,
                     64'h0000000000000001, 10'd0);
        send_request(FUNC_ADD, 64'h7fefffffffffffff, 64'hffefffffffffffff,
                     64'h0000000000000001, 10'd0);
        send_request(FUNC_ADD, 64'h7ff0000000000000, 64'd0, 64'd0, 10'd0);
        send_request(FUNC_ADD, 64'd0, 64'h7ff8000000000000, 64'd0, 10'd0);
        send_request(FUNC_ADD, 64'd0, 64'd0, 64'hfff0000000000000, 10'd0);
        send_request(FUNC_ADD, '1, '1, '1, '1);
        h = sb.point_key(64'd0, 64'd0, 64'd0);
        send_request(FUNC_READ, 64'd0, 64'd0, 64'd0, h[9:0]);
        send_request(FUNC_READ, '1, '1, '1, 10'd0);
        send_request(FUNC_READ, '1, '1, '1, 10'h3ff);
        send_request(FUNC_NONE, '1, '1, '1, '1);
        send_request(FUNC_CLEAR, 64'd0, 64'd0, 64'd0, 10'd0);
        send_request(FUNC_READ, 64'd0, 64'd0, 64'd0, h[9:0]);
        send_request(FUNC_ADD, 64'h8000000000000000, 64'd0, 64'd0, 10'd0);
        send_request(FUNC_READ, 64'd0, 64'd0, 64'd0, h[9:0]);
        send_request(FUNC_ADD, 64'h3ff0000000000000, 64'hbff0000000000000,
                     64'h000fffffffffffff, '1);

        // Mixed traffic over a small point pool; one long receiver hold-off
        for (int i = 0; i < 100; i++) begin
            if (i == 40)
                long_hold_req = 1;
            if (i == 70)
                wait_results_done();
            mixed_request();
        end

        // Fill the table past its load limit, with hits and reads mixed in
        send_request(FUNC_CLEAR, rand64(), rand64(), rand64(), 10'($urandom()));
        for (int i = 0; i < 740; i++) begin
            add_fresh_point();
            if (i % 40 == 39) begin
                add_pool_point();
                send_request(FUNC_READ, rand64(), rand64(), rand64(), 10'($urandom()));
            end
        end

        // Final stretch without idling on either side
        calm = 1;
        for (int i = 0; i < 40; i++)
            mixed_request();
        send_request(FUNC_CLEAR, rand64(), rand64(), rand64(), 10'($urandom()));
        wait_results_done();
        repeat (DRAIN_WAIT) @(negedge clk);

        $display("Covered %0d requests, %0d results checked: %0d hits, %0d invalid, %0d full.",
                 n_sent, sb.checked, sb.n_hit, sb.n_invalid, sb.n_full);
        if (sb.failures == 0 && sb.expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
hdl/epc_pkg.sv
hdl/epc_ram.sv
hdl/epc_hash.sv
hdl/exact_point_count_hash_table.sv
bench/testbench.sv
